[rtl/assert_macros.svh]
// Assertion macros for the checker file.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[rtl/clsl_pkg.sv]
// Shared constants, types and the transmit-bit function for the serial link slave.
// No dependencies.
package clsl_pkg;

  localparam int unsigned POS_W = 5;

  // Frame slot positions, counted from the edge after sync
  localparam logic [POS_W-1:0] SEND_BITS  = 5'd8;
  localparam logic [POS_W-1:0] ACK_SLOT   = 5'd8;
  localparam logic [POS_W-1:0] RECV_FIRST = 5'd9;
  localparam logic [POS_W-1:0] FINAL_SLOT = 5'd25;
  localparam logic [POS_W-1:0] SIGN_SLOT  = 5'd3;

  typedef enum logic {
    CMD_EDGE  = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_t;

  // Control from the frame sequencer to the receive store
  typedef struct packed {
    logic       clear;    // sync edge: zero the receive nibbles
    logic       sample;   // set a receive bit from the line
    logic [1:0] nib;      // nibble index
    logic [1:0] bit_sel;  // bit within nibble
    logic       latch;    // final ack high: copy nibbles to display
  } rx_ctrl_t;

  // Header bits LSB first, then sign, then low 4 bits of the magnitude
  function automatic logic tx_bit(input logic [POS_W-1:0] pos,
                                  input logic [2:0] hdr,
                                  input logic [4:0] chg);
    logic       neg;
    logic [4:0] mag;
    logic       b;
    neg = chg[4];
    mag = neg ? (5'd0 - chg) : chg;
    if (pos < SIGN_SLOT) begin
      b = hdr[pos[1:0]];
    end else if (pos == SIGN_SLOT) begin
      b = neg;
    end else begin
      b = mag[pos[1:0]];
    end
    return b;
  endfunction

endpackage

[rtl/clsl_rx_store.sv]
// Receive nibble store and latched display digits.
// Depends on clsl_pkg.
module clsl_rx_store (
  input  logic                clk,
  input  logic                rst_n,
  input  clsl_pkg::rx_ctrl_t  ctrl,
  input  logic                line,
  output logic [3:0]          digit_a,
  output logic [3:0]          digit_b,
  output logic [3:0]          digit_c,
  output logic [3:0]          digit_d
);

  logic [3:0] nib_r  [4];
  logic [3:0] disp_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        nib_r[i]  <= 4'd0;
        disp_r[i] <= 4'd0;
      end
    end else begin
      if (ctrl.clear) begin
        for (int i = 0; i < 4; i++) begin
          nib_r[i] <= 4'd0;
        end
      end else if (ctrl.sample && line) begin
        nib_r[ctrl.nib][ctrl.bit_sel] <= 1'b1;
      end
      if (ctrl.latch) begin
        for (int i = 0; i < 4; i++) begin
          disp_r[i] <= nib_r[i];
        end
      end
    end
  end

  assign digit_a = disp_r[0];
  assign digit_b = disp_r[1];
  assign digit_c = disp_r[2];
  assign digit_d = disp_r[3];

endmodule

[rtl/clocked_serial_link_slave_unit.sv]
// Results are registered: an accepted input transfer loads the result register.
// Throughput: one item per cycle; the only limit is the single result register,
// which frees when its result is taken, so a new item enters in the same cycle.
// Reset: synchronous, active low; clears sync, bit position, nibbles, display
// digits and the result valid flag. No clearing pass.
// Depends on clsl_pkg and clsl_rx_store.
module clocked_serial_link_slave_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel: one transfer per host clock edge or close command
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [0] line_in, [3:1] action_header,
                                  // [8:4] score_change (signed), [15:9] zero
  input  logic [0:0]  in_tuser,   // [0] command
  // result channel: one transfer per input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] drive_enable, [1] drive_value,
                                  // [2] is_synced, [3] request_consumed,
                                  // [7:4] digit_a, [11:8] digit_b,
                                  // [15:12] digit_c, [19:16] digit_d, [23:20] zero
  output logic        out_tlast   // frame_done
);

  // Input field unpacking
  clsl_pkg::cmd_t   cmd;
  logic             line;
  logic [2:0]       hdr;
  logic [4:0]       chg;

  assign cmd  = clsl_pkg::cmd_t'(in_tuser[0]);
  assign line = in_tdata[0];
  assign hdr  = in_tdata[3:1];
  assign chg  = in_tdata[8:4];

  // Frame state
  logic                      synced_r, synced_nxt;
  logic [clsl_pkg::POS_W-1:0] pos_r, pos_nxt;

  // Result register
  logic out_valid_r;
  logic en_r, en_nxt;
  logic val_r, val_nxt;
  logic done_r, done_nxt;
  logic cons_r, cons_nxt;

  logic                       accept;
  logic [clsl_pkg::POS_W-1:0] k_full;
  clsl_pkg::rx_ctrl_t         rx_ctrl;
  logic [3:0]                 digit_a, digit_b, digit_c, digit_d;

  // Result register frees as its content is taken, so input never waits on it
  // longer than the downstream stall.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Offset into the 16 receive bits
  assign k_full = pos_r - clsl_pkg::RECV_FIRST;

  // Per-edge decision: a handful of compares on the bit position
  always_comb begin
    synced_nxt      = synced_r;
    pos_nxt         = pos_r;
    en_nxt          = 1'b0;
    val_nxt         = 1'b0;
    done_nxt        = 1'b0;
    cons_nxt        = 1'b0;
    rx_ctrl.clear   = 1'b0;
    rx_ctrl.sample  = 1'b0;
    rx_ctrl.nib     = k_full[3:2];
    rx_ctrl.bit_sel = k_full[1:0];
    rx_ctrl.latch   = 1'b0;

    if (cmd == clsl_pkg::CMD_CLOSE) begin
      // close: drop sync, hold the line low; position and nibbles kept
      synced_nxt = 1'b0;
      en_nxt     = 1'b1;
    end else if (!synced_r) begin
      // waiting for sync: line high on an edge starts a frame, line released
      if (line) begin
        synced_nxt    = 1'b1;
        pos_nxt       = '0;
        rx_ctrl.clear = 1'b1;
      end
    end else begin
      if (pos_r < clsl_pkg::SEND_BITS) begin
        en_nxt  = 1'b1;
        val_nxt = clsl_pkg::tx_bit(pos_r, hdr, chg);
      end else if (pos_r == clsl_pkg::ACK_SLOT) begin
        en_nxt  = 1'b1;
        val_nxt = 1'b1;
      end else if (pos_r < clsl_pkg::FINAL_SLOT) begin
        rx_ctrl.sample = 1'b1;
      end

      if (pos_r >= clsl_pkg::FINAL_SLOT) begin
        // final ack slot; a position past it is treated the same and holds
        done_nxt      = 1'b1;
        cons_nxt      = line;
        rx_ctrl.latch = line;
        synced_nxt    = 1'b0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end

    // store only moves on an accepted transfer
    if (!accept) begin
      rx_ctrl.clear  = 1'b0;
      rx_ctrl.sample = 1'b0;
      rx_ctrl.latch  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      synced_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        synced_r    <= synced_nxt;
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      en_r   <= en_nxt;
      val_r  <= val_nxt;
      done_r <= done_nxt;
      cons_r <= cons_nxt;
    end
  end

  // Digits only change on an accepted transfer, which cannot happen while a
  // result is stalled, so they are read straight from the display registers.
  clsl_rx_store u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rx_ctrl),
    .line    (line),
    .digit_a (digit_a),
    .digit_b (digit_b),
    .digit_c (digit_c),
    .digit_d (digit_d)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {4'd0, digit_d, digit_c, digit_b, digit_a,
                       cons_r, synced_r, val_r, en_r};

endmodule

[rtl/clsl_checker.sv]
// Port-level checks for the serial link slave, bound to the top level.
// Depends on assert_macros.svh and clocked_serial_link_slave_unit.
`include "assert_macros.svh"

module clsl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a driven high level needs the driver enabled
  `ASSERT_SAME(a_val_en, out_tvalid && out_tdata[1], out_tdata[0])

  // the final ack ends the frame
  `ASSERT_SAME(a_done_unsync, out_tvalid && out_tlast, !out_tdata[2])

  // consumption only on the final ack
  `ASSERT_SAME(a_cons_done, out_tvalid && out_tdata[3], out_tlast)

  // close command: next result drives low and is unsynced
  `ASSERT_NEXT(a_close, in_tvalid && in_tready && in_tuser[0], out_tvalid && out_tdata[0] && !out_tdata[1] && !out_tdata[2])

endmodule

bind clocked_serial_link_slave_unit clsl_checker u_clsl_checker (.*);

[bench/tb.sv]
// Self-checking bench for clocked_serial_link_slave_unit: directed and random host frames.
// A queue-fed driver and a monitor check every result transfer against a built-in predictor.
// Depends on clsl_pkg (cmd_t) and the unit itself.
`timescale 1ns / 100ps

module tb;

  // Frame slots, counted from the edge after the sync edge
  localparam logic [4:0] SIGN_POS     = 5'd3;
  localparam logic [4:0] N_TX_BITS    = 5'd8;
  localparam logic [4:0] ACK_POS      = 5'd8;
  localparam logic [4:0] RX_FIRST_POS = 5'd9;
  localparam logic [4:0] FINAL_POS    = 5'd25;

  localparam int N_ITEMS    = 1150;
  localparam int IDLE_PCT   = 11;
  localparam int HOLD_AT    = 400;  // accepted count that triggers the long hold-off
  localparam int HOLD_LEN   = 80;
  localparam int QUIET_FROM = 700;  // no idling on either side in this window
  localparam int QUIET_TO   = 900;

  // one host event as the requester side sees it
  typedef struct packed {
    clsl_pkg::cmd_t cmd;
    logic           line;
    logic [2:0]     hdr;
    logic [4:0]     chg;
  } link_item_t;

  // what the slave reports after one event
  typedef struct packed {
    logic            drive_en;
    logic            drive_val;
    logic            synced;
    logic            done;
    logic            consumed;
    logic [3:0][3:0] digits;   // [0] digit_a .. [3] digit_d
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  link_item_t   pending_items[$];
  link_result_t expected_results[$];
  link_item_t   next_item;

  // predictor state
  logic            synced = 1'b0;
  logic [4:0]      bit_pos = '0;
  logic [3:0][3:0] rx_nibbles = '0;
  logic [3:0][3:0] shown_digits = '0;

  int errors = 0;
  int accepted = 0;
  int closes_sent = 0;
  int frames_seen = 0;
  int frames_taken = 0;
  int gen_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  clocked_serial_link_slave_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advances the slave model by one event and returns what it should report.
  function automatic link_result_t predict_slot(clsl_pkg::cmd_t cmd, logic line,
                                                logic [2:0] hdr, logic [4:0] chg);
    link_result_t r;
    logic         neg;
    logic [4:0]   mag;
    logic [4:0]   k;
    r = '0;
    if (cmd == clsl_pkg::CMD_CLOSE) begin
      // IR activity: drop sync and hold the line low; position and nibbles kept
      synced = 1'b0;
      r.drive_en = 1'b1;
    end else if (!synced) begin
      // sync edge clears the receive side; the line stays released
      if (line) begin
        synced = 1'b1;
        rx_nibbles = '0;
        bit_pos = '0;
      end
    end else begin
      if (bit_pos < N_TX_BITS) begin
        // header LSB first, sign, then low four bits of the magnitude
        r.drive_en = 1'b1;
        neg = chg[4];
        mag = neg ? 5'd0 - chg : chg;   // -16 wraps to 16, low bits all zero
        if (bit_pos < SIGN_POS) begin
          r.drive_val = hdr[bit_pos[1:0]];
        end else if (bit_pos == SIGN_POS) begin
          r.drive_val = neg;
        end else begin
          r.drive_val = mag[bit_pos[1:0]];
        end
      end else if (bit_pos == ACK_POS) begin
        r.drive_en = 1'b1;
        r.drive_val = 1'b1;
      end else if (bit_pos < FINAL_POS) begin
        k = bit_pos - RX_FIRST_POS;
        if (line) rx_nibbles[k[3:2]][k[1:0]] = 1'b1;
      end
      if (bit_pos >= FINAL_POS) begin
        // final ack: latch digits only when the host acks high
        r.done = 1'b1;
        if (line) begin
          shown_digits = rx_nibbles;
          r.consumed = 1'b1;
        end
        synced = 1'b0;
      end else begin
        bit_pos = bit_pos + 5'd1;
      end
    end
    r.synced = synced;
    r.digits = shown_digits;
    return r;
  endfunction

  task automatic push_item(clsl_pkg::cmd_t cmd, logic line, logic [2:0] hdr,
                           logic [4:0] chg);
    link_item_t it;
    it.cmd = cmd;
    it.line = line;
    it.hdr = hdr;
    it.chg = chg;
    pending_items.push_back(it);
    gen_count++;
  endtask

  // Sync edge, 8 driven slots, ack, 16 data bits, final ack. A close replaces
  // the event at index cut_at (1..26) when that is in range, ending the frame.
  task automatic push_frame(logic [2:0] hdr, logic [4:0] chg, logic [15:0] data,
                            logic ack, int cut_at, bit wobble);
    logic [2:0] h;
    logic [4:0] c;
    logic       l;
    push_item(clsl_pkg::CMD_EDGE, 1'b1, hdr, chg);
    for (int i = 1; i <= 26; i++) begin
      h = wobble ? 3'($urandom) : hdr;
      c = wobble ? 5'($urandom) : chg;
      if (i == cut_at) begin
        push_item(clsl_pkg::CMD_CLOSE, 1'($urandom), h, c);
        return;
      end
      if (i <= 9) l = 1'($urandom);          // host ignores its own level here
      else if (i <= 25) l = data[i - 10];
      else l = ack;
      push_item(clsl_pkg::CMD_EDGE, l, h, c);
    end
  endtask

  task automatic check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  function automatic bit quiet_window();
    return accepted >= QUIET_FROM && accepted < QUIET_TO;
  endfunction

  // Driver: presents the queue head, predicts each accepted transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_slot(clsl_pkg::cmd_t'(in_tuser[0]), in_tdata[0],
                                                in_tdata[3:1], in_tdata[8:4]));
        accepted <= accepted + 1;
        if (in_tuser[0] == clsl_pkg::CMD_CLOSE) closes_sent <= closes_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 &&
            (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {7'd0, next_item.chg, next_item.hdr, next_item.line};
          in_tuser  <= next_item.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_tready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor: each result transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    link_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual %h last %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("drive_enable", 4'(exp_r.drive_en), 4'(out_tdata[0]));
        check_field("drive_value", 4'(exp_r.drive_val), 4'(out_tdata[1]));
        check_field("is_synced", 4'(exp_r.synced), 4'(out_tdata[2]));
        check_field("request_consumed", 4'(exp_r.consumed), 4'(out_tdata[3]));
        check_field("frame_done", 4'(exp_r.done), 4'(out_tlast));
        for (int i = 0; i < 4; i++) begin
          check_field($sformatf("digit %0d", i), exp_r.digits[i], out_tdata[4 + 4*i +: 4]);
        end
        check_field("padding", 4'd0, out_tdata[23:20]);
        if (out_tlast) frames_seen++;
        if (out_tlast && out_tdata[3]) frames_taken++;
      end
    end
  end

  initial begin : stimulus
    bit maybe_synced;
    int pick;
    int n;
    maybe_synced = 1'b0;

    // directed: idle low edge, close while unsynced, then a full frame with
    // header all ones, the most negative change and all data bits high
    push_item(clsl_pkg::CMD_EDGE, 1'b0, 3'd0, 5'd0);
    push_item(clsl_pkg::CMD_CLOSE, 1'b1, 3'd7, 5'h1f);
    push_frame(3'd7, 5'b10000, 16'hffff, 1'b1, 0, 1'b0);

    // random: mostly well-formed frames, some cut short, idle edges and noise
    while (gen_count < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if (maybe_synced) begin
          push_item(clsl_pkg::CMD_CLOSE, 1'($urandom), 3'($urandom), 5'($urandom));
        end
        push_frame(3'($urandom), 5'($urandom), 16'($urandom),
                   $urandom_range(0, 99) < 75,
                   ($urandom_range(0, 99) < 12) ? $urandom_range(1, 26) : 0,
                   $urandom_range(0, 9) == 0);
        maybe_synced = 1'b0;
      end else if (pick < 82) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          push_item(clsl_pkg::CMD_EDGE, 1'b0, 3'($urandom), 5'($urandom));
        end
        if (!maybe_synced) gen_count -= n;   // ignored edges
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          push_item(($urandom_range(0, 99) < 20) ? clsl_pkg::CMD_CLOSE : clsl_pkg::CMD_EDGE,
                    1'($urandom), 3'($urandom), 5'($urandom));
        end
        maybe_synced = 1'b1;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("Covered %0d input transfers incl. %0d close commands; %0d frames ended,",
             accepted, closes_sent, frames_seen);
    $display("%0d of them acked high and latched new digits; %0d errors", frames_taken, errors);
    if (errors == 0) begin
      $display("clocked_serial_link_slave_unit test passed");
    end else begin
      $display("clocked_serial_link_slave_unit test failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("%0t: timeout, %0d items still queued", $time, pending_items.size());
    $display("clocked_serial_link_slave_unit test failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/clsl_pkg.sv
rtl/clsl_rx_store.sv
rtl/clocked_serial_link_slave_unit.sv
rtl/clsl_checker.sv
bench/tb.sv
